### rtl/core/b64e_pkg.sv
// b64e_pkg: shared types, constants and the alphabet lookup for the base64 encoder
// no dependencies; used by every module of the encoder

package b64e_pkg;

    // default depth of the queue between front and back
    localparam int FifoDepth = 2;

    // ascii code of the pad character
    localparam logic [7:0] PadChar = 8'h3D;

    // one output symbol: alphabet index or pad
    typedef struct packed {
        logic       pad;
        logic [5:0] idx;
    } t_sym;

    // one queued command: up to four symbols for one accepted byte
    typedef struct packed {
        t_sym [3:0] syms;
        logic [1:0] last_idx;
        logic       eom;
    } t_cmd;

    // map a symbol to its ascii character (standard alphabet)
    function automatic logic [7:0] sym_char(input t_sym s);
        logic [7:0] v;
        logic [7:0] c;
        v = {2'b00, s.idx};
        if (s.pad) begin
            c = PadChar;
        end else if (v < 8'd26) begin
            c = 8'h41 + v;
        end else if (v < 8'd52) begin
            c = 8'h61 + (v - 8'd26);
        end else if (v < 8'd62) begin
            c = 8'h30 + (v - 8'd52);
        end else if (v == 8'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

### rtl/core/b64e_if.sv
// b64e_byte_if and b64e_char_if: valid/ready channels of the base64 encoder
// no dependencies

interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_message;

    modport source (output valid, output out_char, output end_of_message, input ready);
    modport sink   (input valid, input out_char, input end_of_message, output ready);
endinterface

### rtl/core/b64e_front.sv
// b64e_front: accepts raw bytes, tracks group phase and carry bits, builds symbol commands
// depends on b64e_pkg and b64e_byte_if

module b64e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b64e_byte_if.sink        i_byte,
    input  logic             i_full,
    output logic             o_push,
    output b64e_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] PhaseFirst  = 2'd0;
    localparam logic [1:0] PhaseSecond = 2'd1;
    localparam logic [1:0] PhaseThird  = 2'd2;

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic [3:0] r_carry;
    logic [3:0] n_carry;
    logic [7:0] b;
    logic       last;

    assign b      = i_byte.data_byte;
    assign last   = i_byte.last_byte;
    assign i_byte.ready = !i_full;
    assign o_push = i_byte.valid && !i_full;

    // classify the byte by group position and build its symbols
    always_comb begin
        o_cmd     = '0;
        o_cmd.eom = last;
        n_phase   = r_phase;
        n_carry   = r_carry;
        unique case (r_phase)
            PhaseSecond: begin
                o_cmd.syms[0].idx = {r_carry[1:0], b[7:4]};
                o_cmd.syms[1].idx = {b[3:0], 2'b00};
                o_cmd.syms[2].pad = 1'b1;
                o_cmd.last_idx    = last ? 2'd2 : 2'd0;
                n_phase           = PhaseThird;
                n_carry           = b[3:0];
            end
            PhaseThird: begin
                o_cmd.syms[0].idx = {r_carry, b[7:6]};
                o_cmd.syms[1].idx = b[5:0];
                o_cmd.last_idx    = 2'd1;
                n_phase           = PhaseFirst;
                n_carry           = 4'd0;
            end
            default: begin
                o_cmd.syms[0].idx = b[7:2];
                o_cmd.syms[1].idx = {b[1:0], 4'b0000};
                o_cmd.syms[2].pad = 1'b1;
                o_cmd.syms[3].pad = 1'b1;
                o_cmd.last_idx    = last ? 2'd3 : 2'd0;
                n_phase           = PhaseSecond;
                n_carry           = {2'b00, b[1:0]};
            end
        endcase
        if (last) begin
            n_phase = PhaseFirst;
            n_carry = 4'd0;
        end
    end

    // phase and carry advance on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhaseFirst;
            r_carry <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

### rtl/core/b64e_fifo.sv
// b64e_fifo: short command queue between the front and back of the encoder
// depends on b64e_pkg

module b64e_fifo #(
    parameter int Depth = b64e_pkg::FifoDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_cmd   i_wdata,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output b64e_pkg::t_cmd   o_rdata
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    b64e_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/b64e_back.sv
// b64e_back: walks queued commands and sends one character per transfer
// depends on b64e_pkg and b64e_char_if

module b64e_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  b64e_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    b64e_char_if.source      o_char
);

    b64e_pkg::t_cmd r_cmd;
    logic [1:0]     r_idx;
    logic           r_busy;
    logic           r_out_valid;
    logic [7:0]     r_out_char;
    logic           r_out_eom;
    logic           adv;
    logic           at_end;
    logic           done;

    assign o_char.valid          = r_out_valid;
    assign o_char.out_char       = r_out_char;
    assign o_char.end_of_message = r_out_eom;

    assign adv       = !r_out_valid || o_char.ready;
    assign at_end    = (r_idx == r_cmd.last_idx);
    assign done      = !r_busy || (adv && at_end);
    assign o_cmd_pop = done && i_cmd_valid;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_char <= b64e_pkg::sym_char(r_cmd.syms[r_idx]);
            r_out_eom  <= r_cmd.eom && at_end;
        end
    end

    // command walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_cmd_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // index never runs past the command's last symbol
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_cmd.last_idx))
        else $error("symbol index past end of command");

    // an idle walker picks up a waiting command at once
    a_pickup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && !r_busy) |=> r_busy)
        else $error("waiting command not picked up");

    // a busy walker with a free output register fills it
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_busy) |=> r_out_valid)
        else $error("output register not filled");

endmodule

### rtl/core/base64_stream_encoder_core.sv
// base64_stream_encoder_core: top level of the streaming base64 encoder
// depends on b64e_pkg, b64e_if, b64e_front, b64e_fifo, b64e_back
// path: a byte's command passes the queue, the command register and the output register
// throughput: one character per cycle while o_char is ready, set by the output channel;
// a byte gives 1 to 4 characters (4 per 3 bytes mid-message); the queue lets input run ahead
// reset: synchronous active-low, clears phase, carry, queue and output valid

module base64_stream_encoder_core #(
    parameter int Depth = b64e_pkg::FifoDepth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64e_byte_if.sink    i_byte,
    b64e_char_if.source  o_char
);

    b64e_pkg::t_cmd push_cmd;
    b64e_pkg::t_cmd head_cmd;
    logic           push;
    logic           full;
    logic           head_valid;
    logic           pop;

    // byte intake and symbol building
    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // command queue
    b64e_fifo #(
        .Depth (Depth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_rdata (head_cmd)
    );

    // character output
    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_char      (o_char)
    );

endmodule

### dv/tb_base64_stream_encoder_core.sv
// tb_base64_stream_encoder_core: self-checking bench for the streaming base64 encoder
// depends on b64e_pkg, b64e_byte_if, b64e_char_if and base64_stream_encoder_core
// drives whole messages with random gaps and stalls, checks each character in order

module tb_base64_stream_encoder_core;

    localparam int CycleLimit  = 200000;
    localparam int TargetBytes = 460;

    // one character the encoder owes us
    typedef struct {
        logic [7:0] ch;
        logic       eom;
    } t_owed_char;

    // tracks group position and leftover bits, predicts the emitted characters
    class b64_char_scoreboard;
        string       alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                 "abcdefghijklmnopqrstuvwxyz", "0123456789+/"};
        t_owed_char  owed_chars[$];
        logic [3:0]  leftover;
        logic [1:0]  group_pos;
        int          errors;
        int          bytes_seen;
        int          chars_seen;
        int          msgs_seen;

        function new();
            leftover   = '0;
            group_pos  = '0;
            errors     = 0;
            bytes_seen = 0;
            chars_seen = 0;
            msgs_seen  = 0;
        endfunction

        function void owe(input logic [5:0] sextet, input logic is_pad, input logic eom);
            t_owed_char c;
            c.ch  = is_pad ? b64e_pkg::PadChar : 8'(alphabet[sextet]);
            c.eom = eom;
            owed_chars = {owed_chars, c};
        endfunction

        // input transfer: work out the characters this byte completes
        function void note_byte(input logic [7:0] b, input logic is_last);
            bytes_seen++;
            case (group_pos)
                2'd1: begin
                    owe({leftover[1:0], b[7:4]}, 1'b0, 1'b0);
                    leftover  = b[3:0];
                    group_pos = 2'd2;
                    if (is_last) begin
                        owe({leftover, 2'b00}, 1'b0, 1'b0);
                        owe('0, 1'b1, 1'b1);
                    end
                end
                2'd2: begin
                    owe({leftover, b[7:6]}, 1'b0, 1'b0);
                    owe(b[5:0], 1'b0, is_last);
                    leftover  = '0;
                    group_pos = 2'd0;
                end
                // start of group; the unused code behaves the same way
                default: begin
                    owe(b[7:2], 1'b0, 1'b0);
                    leftover  = {2'b00, b[1:0]};
                    group_pos = 2'd1;
                    if (is_last) begin
                        owe({leftover[1:0], 4'b0000}, 1'b0, 1'b0);
                        owe('0, 1'b1, 1'b0);
                        owe('0, 1'b1, 1'b1);
                    end
                end
            endcase
            if (is_last) begin
                leftover  = '0;
                group_pos = '0;
                msgs_seen++;
            end
        endfunction

        // output transfer: compare with the oldest owed character
        function void check_char(input logic [7:0] ch, input logic eom);
            t_owed_char c;
            chars_seen++;
            if (owed_chars.size() == 0) begin
                $error("unexpected character: out_char %h end_of_message %b", ch, eom);
                errors++;
                return;
            end
            c = owed_chars.pop_front();
            if (ch !== c.ch) begin
                $error("out_char mismatch: expected %h actual %h", c.ch, ch);
                errors++;
            end
            if (eom !== c.eom) begin
                $error("end_of_message mismatch: expected %b actual %b", c.eom, eom);
                errors++;
            end
        endfunction

        function int pending();
            return owed_chars.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   bytes_sent;

    b64e_byte_if byte_ch ();
    b64e_char_if char_ch ();

    b64_char_scoreboard sb = new();

    base64_stream_encoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_char  (char_ch)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_base64_stream_encoder_core NOT OK");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        char_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // transfer monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                sb.note_byte(byte_ch.data_byte, byte_ch.last_byte);
            end
            if (char_ch.valid && char_ch.ready) begin
                sb.check_char(char_ch.out_char, char_ch.end_of_message);
            end
        end
    end

    // present one byte after a random gap, return at the falling edge after its transfer
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= is_last;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // random message, mostly short with the odd long one
    task automatic send_message();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cycle_count       = 0;
        bytes_sent        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        char_ch.ready     = 1'b0;

        // reset
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: one, two, three and four byte messages, all-zero and all-one bytes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);

        // random messages under four idling mixes
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            while (bytes_sent < 19 + (p + 1) * (TargetBytes - 19) / 4) begin
                send_message();
            end
        end
        byte_ch.valid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("encoded %0d bytes in %0d messages, %0d characters checked",
                 sb.bytes_seen, sb.msgs_seen, sb.chars_seen);
        $display("idling mixes: none, sender gaps, receiver stalls, both");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_base64_stream_encoder_core OK");
        end else begin
            $display("tb_base64_stream_encoder_core NOT OK");
        end
        $finish;
    end

endmodule
